>>> sv/mbm_pkg.sv
// Shared types, codes and CRC helper for the Modbus RTU master engine.
package mbm_pkg;

  typedef enum logic [2:0] {
    MODE_RD_REGS  = 3'd0,
    MODE_RD_COILS = 3'd1,
    MODE_WR_REG   = 3'd2,
    MODE_WR_COIL  = 3'd3,
    MODE_RX       = 3'd4,
    MODE_GET_REG  = 3'd5,
    MODE_GET_COIL = 3'd6,
    MODE_NONE     = 3'd7
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  slave_addr;
    logic [15:0] item_addr;
    logic [15:0] count_or_value;
    logic [7:0]  store_index;
    logic [7:0]  rx_byte;
    logic        rx_last;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        last;
    logic [1:0]  status;
    logic [15:0] read_value;
  } res_t;

  // request header handed to the frame serializer
  typedef struct packed {
    logic [7:0]  addr;
    logic [7:0]  fn;
    logic [15:0] item;
    logic [15:0] value;
  } frame_t;

  // serializer status back to the sequencer
  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } tx_stat_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_TX, S_APPLY, S_RR_A, S_RR_B, S_RR_C,
    S_CO_A, S_CO_B, S_Q_ADDR, S_Q_DATA
  } state_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SLAVE = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;

  localparam logic [7:0] FN_READ_REGS  = 8'h03;
  localparam logic [7:0] FN_READ_COILS = 8'h01;
  localparam logic [7:0] FN_WRITE_REG  = 8'h06;
  localparam logic [7:0] FN_WRITE_COIL = 8'h05;

  localparam logic [2:0] CFG_MASK  = 3'd0;
  localparam logic [2:0] CFG_ADDR0 = 3'd1;
  localparam logic [2:0] CFG_ADDR1 = 3'd2;
  localparam logic [2:0] CFG_ADDR2 = 3'd3;
  localparam logic [2:0] CFG_ADDR3 = 3'd4;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  // 0x8005 bit-reversed
  localparam logic [15:0] CRC_POLY_REV = 16'hA001;
  localparam logic [8:0]  RX_COUNT_MAX = 9'd511;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REV) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> sv/mbm_ram.sv
// Generic simple dual-port RAM with registered read.
module mbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/mbm_tx.sv
// Request frame serializer: eight bytes with CRC-16 built byte by byte.
module mbm_tx
  import mbm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  frame_t   hdr,
  output tx_stat_t tx
);
  frame_t      frame;
  logic [15:0] crc;
  logic [2:0]  k;
  logic        active;
  logic [7:0]  cur;

  always_comb begin
    unique case (k)
      3'd0: cur = frame.addr;
      3'd1: cur = frame.fn;
      3'd2: cur = frame.item[15:8];
      3'd3: cur = frame.item[7:0];
      3'd4: cur = frame.value[15:8];
      3'd5: cur = frame.value[7:0];
      3'd6: cur = crc[7:0];
      default: cur = crc[15:8];
    endcase
  end

  assign tx.valid = active;
  assign tx.last  = active && (k == 3'd7);
  assign tx.data  = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      k      <= 3'd0;
    end else if (load) begin
      active <= 1'b1;
      k      <= 3'd0;
    end else if (active) begin
      k <= k + 3'd1;
      if (k == 3'd7) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= hdr;
      crc   <= CRC_INIT;
    end else if (active && (k < 3'd6)) begin
      crc <= crc_byte(crc, cur);
    end
  end
endmodule

>>> sv/modbus_rtu_master_engine.sv
// Top level of the Modbus RTU master engine: sequencer, stores and rx buffer.
//
// A command (modes 0..3) to a configured slave gives eight request bytes, one
// per cycle, via the serializer and the result register; CRC is folded in one
// byte per cycle by the serializer. busy stays high while the serializer emits
// the eight bytes. Rx bytes (mode 4) that are not last leave busy low and
// give no result. A last rx byte applies the response from the rx buffer RAM
// after a decision state: read registers pass S_RR_A, S_RR_B, S_RR_C per
// stored value (two buffer reads through its single read port, then a store
// write), read coils S_CO_A, S_CO_B per byte; a response that stores nothing
// is done after the decision state. The registered result follows in the cycle
// after the last busy cycle. Queries (modes 5, 6) keep busy high through
// S_Q_ADDR and S_Q_DATA for the store's registered read. Every result is shown
// for one cycle with strobe; the receiver cannot stall it. After reset the
// register and coil stores are cleared, one entry per cycle, over
// max(MAX_SLAVES*REGS_PER_SLAVE, MAX_SLAVES*COIL_BYTES_PER_SLAVE) entries
// (1024 by default) while busy stays high; configuration writes take effect
// at the edge they are given, including during that sweep, and must be
// changed only while nothing is in flight; the block does not enforce this.
module modbus_rtu_master_engine
  import mbm_pkg::*;
#(
  parameter int MAX_SLAVES           = 4,
  parameter int REGS_PER_SLAVE       = 256,
  parameter int COIL_BYTES_PER_SLAVE = 64,
  parameter int RX_BUFFER_BYTES      = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  cmd_t       cmd,
  output logic       strobe,
  output res_t       result,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  localparam int REG_DEPTH  = MAX_SLAVES * REGS_PER_SLAVE;
  localparam int COIL_DEPTH = MAX_SLAVES * COIL_BYTES_PER_SLAVE;
  localparam int RAW = REG_DEPTH > 1 ? $clog2(REG_DEPTH) : 1;
  localparam int CAW = COIL_DEPTH > 1 ? $clog2(COIL_DEPTH) : 1;
  localparam int RXW = $clog2(RX_BUFFER_BYTES);
  localparam int CLR_DEPTH = REG_DEPTH > COIL_DEPTH ? REG_DEPTH : COIL_DEPTH;
  localparam int CLW = CLR_DEPTH > 1 ? $clog2(CLR_DEPTH) : 1;
  localparam int MAXPS = REGS_PER_SLAVE > COIL_BYTES_PER_SLAVE ?
                         REGS_PER_SLAVE : COIL_BYTES_PER_SLAVE;
  localparam int OFFW = $clog2(MAXPS + 257);
  localparam int PTRW = $clog2(2 * REGS_PER_SLAVE + 520);

  // ---------------- state ----------------
  state_t state, state_next;
  logic [3:0]  mask;
  logic [7:0]  saddr [4];
  logic [8:0]  rx_count;
  logic [1:0]  p_slot;
  logic [7:0]  p_fn;
  logic [15:0] p_count;
  logic [7:0]  p_index;
  logic [8:0]  len;
  logic [CLW-1:0]  clr_idx;
  logic [1:0]      cur_slot;
  logic [OFFW-1:0] off;
  logic [PTRW-1:0] ptr;
  logic [15:0]     rem;
  logic [7:0]      hi;
  logic            rx_oob;
  logic            q_coil;
  logic            q_in;

  logic accept;
  logic found;
  logic [1:0] slot;
  logic strobe_next;
  res_t res_next;

  // memory ports
  logic            reg_we, coil_we, rx_we;
  logic [RAW-1:0]  reg_raddr, reg_waddr;
  logic [15:0]     reg_wdata, reg_rdata;
  logic [CAW-1:0]  coil_raddr, coil_waddr;
  logic [7:0]      coil_wdata, coil_rdata;
  logic [RXW-1:0]  rx_waddr;
  logic [7:0]      rx_rdata, rx_data;
  logic [31:0]     reg_lin, coil_lin;

  // frame serializer
  logic     tx_load;
  frame_t   frame;
  tx_stat_t tx;

  // response apply decision
  logic        go_rr, go_co;
  logic [1:0]  app_stat;
  logic [13:0] nbytes;
  logic        slot_ok;
  logic        rr_more, co_more;
  logic [8:0]  rx_inc;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // lowest enabled slot with a matching address
  always_comb begin
    found = 1'b0;
    slot  = 2'd0;
    for (int s = MAX_SLAVES - 1; s >= 0; s--) begin
      if (mask[s] && (saddr[s] == cmd.slave_addr)) begin
        found = 1'b1;
        slot  = 2'(s);
      end
    end
  end

  assign reg_lin    = 32'(cur_slot) * 32'(REGS_PER_SLAVE) + 32'(off);
  assign coil_lin   = 32'(cur_slot) * 32'(COIL_BYTES_PER_SLAVE) + 32'(off);
  assign reg_raddr  = reg_lin[RAW-1:0];
  assign coil_raddr = coil_lin[CAW-1:0];
  assign rx_data    = rx_oob ? 8'h00 : rx_rdata;
  assign rx_inc     = (rx_count < RX_COUNT_MAX) ? rx_count + 9'd1 : rx_count;
  assign rx_waddr   = rx_count[RXW-1:0];

  always_comb begin
    frame.addr  = cmd.slave_addr;
    frame.item  = cmd.item_addr;
    frame.value = cmd.count_or_value;
    unique case (cmd.mode)
      MODE_RD_REGS:  frame.fn = FN_READ_REGS;
      MODE_RD_COILS: frame.fn = FN_READ_COILS;
      MODE_WR_REG:   frame.fn = FN_WRITE_REG;
      default:       frame.fn = FN_WRITE_COIL;
    endcase
  end

  // loop continuation after the current store write
  assign rr_more = (rem != 16'd1) && ((off + OFFW'(1)) < OFFW'(REGS_PER_SLAVE));
  assign co_more = (rem != 16'd1) && ((off + OFFW'(1)) < OFFW'(COIL_BYTES_PER_SLAVE));

  // what a finished response does, from pending command and length
  always_comb begin
    nbytes   = 14'((17'(p_count) + 17'd7) >> 3);
    slot_ok  = ({1'b0, p_slot} < 3'(MAX_SLAVES)) && mask[p_slot];
    go_rr    = 1'b0;
    go_co    = 1'b0;
    app_stat = ST_OK;
    if (len < 9'd5) begin
      app_stat = ST_BAD_LEN;
    end else if (!slot_ok) begin
      app_stat = ST_NO_SLAVE;
    end else begin
      priority case (p_fn)
        FN_READ_REGS: begin
          go_rr = (p_count != 16'd0) && (OFFW'(p_index) < OFFW'(REGS_PER_SLAVE));
        end
        FN_WRITE_REG: begin
          if (len != 9'd8) app_stat = ST_BAD_LEN;
          else go_rr = OFFW'(p_index) < OFFW'(REGS_PER_SLAVE);
        end
        FN_READ_COILS: begin
          if (14'(len) != nbytes + 14'd5) app_stat = ST_BAD_LEN;
          else go_co = (nbytes != 14'd0) &&
                       (OFFW'(p_index) < OFFW'(COIL_BYTES_PER_SLAVE));
        end
        FN_WRITE_COIL: begin
          if (len != 9'd8) app_stat = ST_BAD_LEN;
        end
        default: app_stat = ST_OK;
      endcase
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_idx == CLW'(CLR_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (cmd.mode)
            MODE_RD_REGS, MODE_RD_COILS, MODE_WR_REG, MODE_WR_COIL:
              if (found) state_next = S_TX;
            MODE_RX:
              if (cmd.rx_last) state_next = S_APPLY;
            MODE_GET_REG, MODE_GET_COIL:
              if (found) state_next = S_Q_ADDR;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_TX:     if (tx.last) state_next = S_IDLE;
      S_APPLY:  state_next = go_rr ? S_RR_A : (go_co ? S_CO_A : S_IDLE);
      S_RR_A:   state_next = S_RR_B;
      S_RR_B:   state_next = S_RR_C;
      S_RR_C:   state_next = rr_more ? S_RR_A : S_IDLE;
      S_CO_A:   state_next = S_CO_B;
      S_CO_B:   state_next = co_more ? S_CO_A : S_IDLE;
      S_Q_ADDR: state_next = S_Q_DATA;
      S_Q_DATA: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // ---------------- outputs ----------------
  always_comb begin
    strobe_next = 1'b0;
    res_next    = '0;
    tx_load     = 1'b0;
    reg_we      = 1'b0;
    reg_waddr   = reg_raddr;
    reg_wdata   = {hi, rx_data};
    coil_we     = 1'b0;
    coil_waddr  = coil_raddr;
    coil_wdata  = rx_data;
    rx_we       = 1'b0;
    unique case (state)
      S_CLEAR: begin
        reg_we     = ({1'b0, clr_idx} < (CLW + 1)'(REG_DEPTH));
        reg_waddr  = clr_idx[RAW-1:0];
        reg_wdata  = 16'h0000;
        coil_we    = ({1'b0, clr_idx} < (CLW + 1)'(COIL_DEPTH));
        coil_waddr = clr_idx[CAW-1:0];
        coil_wdata = 8'h00;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (cmd.mode)
            MODE_RD_REGS, MODE_RD_COILS, MODE_WR_REG, MODE_WR_COIL,
            MODE_GET_REG, MODE_GET_COIL: begin
              if (!found) begin
                strobe_next     = 1'b1;
                res_next.last   = 1'b1;
                res_next.status = ST_NO_SLAVE;
              end else if (cmd.mode != MODE_GET_REG && cmd.mode != MODE_GET_COIL) begin
                tx_load = 1'b1;
              end
            end
            MODE_RX: begin
              rx_we = (rx_count < 9'(RX_BUFFER_BYTES));
            end
            default: begin
              strobe_next   = 1'b1;
              res_next.last = 1'b1;
            end
          endcase
        end
      end
      S_TX: begin
        strobe_next       = tx.valid;
        res_next.tx_byte  = tx.data;
        res_next.tx_valid = tx.valid;
        res_next.last     = tx.last;
      end
      S_APPLY: begin
        if (!go_rr && !go_co) begin
          strobe_next     = 1'b1;
          res_next.last   = 1'b1;
          res_next.status = app_stat;
        end
      end
      S_RR_C: begin
        reg_we = 1'b1;
        if (!rr_more) begin
          strobe_next   = 1'b1;
          res_next.last = 1'b1;
        end
      end
      S_CO_B: begin
        coil_we = 1'b1;
        if (!co_more) begin
          strobe_next   = 1'b1;
          res_next.last = 1'b1;
        end
      end
      S_Q_DATA: begin
        strobe_next   = 1'b1;
        res_next.last = 1'b1;
        if (q_in) begin
          res_next.read_value = q_coil ? {8'h00, coil_rdata} : reg_rdata;
        end
      end
      default: begin
        strobe_next = 1'b0;
      end
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      strobe   <= 1'b0;
      mask     <= 4'h0;
      saddr    <= '{default: 8'h00};
      rx_count <= 9'd0;
      p_slot   <= 2'd0;
      p_fn     <= 8'h00;
      p_count  <= 16'h0000;
      p_index  <= 8'h00;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + CLW'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MASK:  mask     <= cfg_data[3:0];
          CFG_ADDR0: saddr[0] <= cfg_data;
          CFG_ADDR1: saddr[1] <= cfg_data;
          CFG_ADDR2: saddr[2] <= cfg_data;
          CFG_ADDR3: saddr[3] <= cfg_data;
          default:   mask     <= mask;
        endcase
      end
      if (accept && cmd.mode == MODE_RX) begin
        rx_count <= cmd.rx_last ? 9'd0 : rx_inc;
      end
      if (tx_load) begin
        p_slot  <= slot;
        p_fn    <= frame.fn;
        p_count <= (cmd.mode == MODE_RD_REGS || cmd.mode == MODE_RD_COILS) ?
                   cmd.count_or_value : 16'd1;
        p_index <= cmd.store_index;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    result <= res_next;
    rx_oob <= (ptr >= PTRW'(RX_BUFFER_BYTES));
    if (accept && cmd.mode == MODE_RX) begin
      len <= rx_inc;
    end
    unique case (state)
      S_IDLE: begin
        cur_slot <= slot;
        off      <= OFFW'(cmd.store_index);
        q_coil   <= (cmd.mode == MODE_GET_COIL);
        q_in     <= (cmd.mode == MODE_GET_COIL) ?
                    (OFFW'(cmd.store_index) < OFFW'(COIL_BYTES_PER_SLAVE)) :
                    (OFFW'(cmd.store_index) < OFFW'(REGS_PER_SLAVE));
      end
      S_APPLY: begin
        cur_slot <= p_slot;
        off      <= OFFW'(p_index);
        ptr      <= (p_fn == FN_WRITE_REG) ? PTRW'(4) : PTRW'(3);
        rem      <= go_co ? 16'(nbytes) : p_count;
      end
      S_RR_A: ptr <= ptr + PTRW'(1);
      S_RR_B: begin
        ptr <= ptr + PTRW'(1);
        hi  <= rx_data;
      end
      S_RR_C, S_CO_B: begin
        off <= off + OFFW'(1);
        rem <= rem - 16'd1;
      end
      S_CO_A: ptr <= ptr + PTRW'(1);
      default: hi <= hi;
    endcase
  end

  // ---------------- memories ----------------
  mbm_ram #(.WIDTH(16), .DEPTH(REG_DEPTH)) u_reg_store (
    .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
    .raddr(reg_raddr), .rdata(reg_rdata)
  );

  mbm_ram #(.WIDTH(8), .DEPTH(COIL_DEPTH)) u_coil_store (
    .clk(clk), .we(coil_we), .waddr(coil_waddr), .wdata(coil_wdata),
    .raddr(coil_raddr), .rdata(coil_rdata)
  );

  mbm_ram #(.WIDTH(8), .DEPTH(RX_BUFFER_BYTES)) u_rx_buf (
    .clk(clk), .we(rx_we), .waddr(rx_waddr), .wdata(cmd.rx_byte),
    .raddr(ptr[RXW-1:0]), .rdata(rx_rdata)
  );

  mbm_tx u_tx (
    .clk(clk), .rst(rst), .load(tx_load), .hdr(frame), .tx(tx)
  );

  // ---------------- assertions ----------------
  a_tx_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.tx_valid) |-> (result.status == ST_OK))
    else $error("request byte carries a nonzero status");

  a_rx_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.mode == MODE_RX && !cmd.rx_last) |=> !strobe)
    else $error("rx byte that is not last produced a result");

  a_idle_no_tx: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !tx.valid)
    else $error("serializer active while sequencer idle");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !strobe)
    else $error("result during store clearing");
endmodule

>>> tb/mbm_checker.sv
// Checker for the Modbus RTU master engine: predicts results per transfer and compares.
`timescale 1ns / 100ps
module mbm_checker
  import mbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  cmd_t       cmd,
  input  logic       strobe,
  input  res_t       result,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending_results
);

  localparam int NSLOT = 4;
  localparam int NREG  = 256;
  localparam int NCOIL = 64;
  localparam int RXLEN = 256;

  logic [3:0]  en_mask;
  logic [7:0]  slot_addr [NSLOT];
  logic [15:0] reg_mem [NSLOT*NREG];
  logic [7:0]  coil_mem [NSLOT*NCOIL];
  logic [7:0]  rx_mem [RXLEN];
  logic [8:0]  rx_len;
  int          cur_slot;
  logic [7:0]  cur_fn;
  logic [15:0] cur_count;
  logic [7:0]  cur_index;
  res_t        expected_results[$];

  assign pending_results = expected_results.size();

  function automatic int lookup_slot(logic [7:0] a);
    for (int s = 0; s < NSLOT; s++)
      if (en_mask[s] && slot_addr[s] == a) return s;
    return -1;
  endfunction

  function automatic logic [7:0] rx_at(int p);
    return (p < RXLEN) ? rx_mem[p] : 8'h00;
  endfunction

  function automatic res_t mk(logic [7:0] b, logic v, logic l, logic [1:0] st,
                              logic [15:0] rv);
    res_t r;
    r.tx_byte = b; r.tx_valid = v; r.last = l; r.status = st; r.read_value = rv;
    return r;
  endfunction

  function automatic logic [1:0] apply_reply(int len);
    int nb;
    if (len < 5) return ST_BAD_LEN;
    if (!en_mask[cur_slot]) return ST_NO_SLAVE;
    case (cur_fn)
      FN_READ_REGS: begin
        for (int i = 0; i < cur_count && cur_index + i < NREG; i++)
          reg_mem[cur_slot*NREG + cur_index + i] = {rx_at(3+2*i), rx_at(4+2*i)};
      end
      FN_WRITE_REG: begin
        if (len != 8) return ST_BAD_LEN;
        reg_mem[cur_slot*NREG + cur_index] = {rx_at(4), rx_at(5)};
      end
      FN_READ_COILS: begin
        nb = (int'(cur_count) + 7) / 8;
        if (len != nb + 5) return ST_BAD_LEN;
        for (int i = 0; i < nb && cur_index + i < NCOIL; i++)
          coil_mem[cur_slot*NCOIL + cur_index + i] = rx_at(3+i);
      end
      FN_WRITE_COIL: if (len != 8) return ST_BAD_LEN;
      default: ;
    endcase
    return ST_OK;
  endfunction

  // work out the results of one accepted command
  task automatic predict_cmd(cmd_t c);
    logic [7:0]  fr[8];
    logic [15:0] crc;
    logic [15:0] val;
    logic [1:0]  st;
    int s;
    case (c.mode)
      MODE_RD_REGS, MODE_RD_COILS, MODE_WR_REG, MODE_WR_COIL: begin
        s = lookup_slot(c.slave_addr);
        if (s < 0) begin
          expected_results.push_back(mk(0, 0, 1, ST_NO_SLAVE, 0));
        end else begin
          fr[0] = c.slave_addr;
          fr[1] = (c.mode == MODE_RD_REGS) ? FN_READ_REGS :
                  (c.mode == MODE_RD_COILS) ? FN_READ_COILS :
                  (c.mode == MODE_WR_REG) ? FN_WRITE_REG : FN_WRITE_COIL;
          fr[2] = c.item_addr[15:8]; fr[3] = c.item_addr[7:0];
          fr[4] = c.count_or_value[15:8]; fr[5] = c.count_or_value[7:0];
          crc = 16'hFFFF;
          for (int k = 0; k < 6; k++) begin
            crc ^= {8'h00, fr[k]};
            for (int b = 0; b < 8; b++)
              crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
          end
          fr[6] = crc[7:0]; fr[7] = crc[15:8];
          cur_slot = s; cur_fn = fr[1];
          cur_count = (c.mode <= MODE_RD_COILS) ? c.count_or_value : 16'd1;
          cur_index = c.store_index;
          for (int k = 0; k < 8; k++)
            expected_results.push_back(mk(fr[k], 1, k == 7, ST_OK, 0));
        end
      end
      MODE_RX: begin
        if (rx_len < RXLEN) rx_mem[rx_len] = c.rx_byte;
        if (rx_len != 9'd511) rx_len++;
        if (c.rx_last) begin
          st = apply_reply(rx_len);
          rx_len = 0;
          expected_results.push_back(mk(0, 0, 1, st, 0));
        end
      end
      MODE_GET_REG, MODE_GET_COIL: begin
        s = lookup_slot(c.slave_addr);
        if (s < 0) begin
          expected_results.push_back(mk(0, 0, 1, ST_NO_SLAVE, 0));
        end else begin
          val = 0;
          if (c.mode == MODE_GET_REG) val = reg_mem[s*NREG + c.store_index];
          else if (c.store_index < NCOIL) val = {8'h00, coil_mem[s*NCOIL + c.store_index]};
          expected_results.push_back(mk(0, 0, 1, ST_OK, val));
        end
      end
      default: expected_results.push_back(mk(0, 0, 1, ST_OK, 0));
    endcase
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      en_mask <= 0; rx_len <= 0; cur_slot <= 0; cur_fn <= 0;
      cur_count <= 0; cur_index <= 0; fail_count <= 0;
      for (int s = 0; s < NSLOT; s++) slot_addr[s] <= 0;
      for (int i = 0; i < NSLOT*NREG; i++) reg_mem[i] <= 0;
      for (int i = 0; i < NSLOT*NCOIL; i++) coil_mem[i] <= 0;
    end else begin
      if (strobe) begin
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", result);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (result !== e) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", e, result);
            fail_count <= fail_count + 1;
          end
        end
      end
      // a transfer at this edge still sees the settings from before it
      if (start && !busy) predict_cmd(cmd);
      if (cfg_we) begin
        if (cfg_index == CFG_MASK) en_mask = cfg_data[3:0];
        else if (cfg_index <= CFG_ADDR3) slot_addr[cfg_index - 1] = cfg_data;
      end
    end
  end

endmodule

>>> tb/tb_modbus_rtu_master_engine.sv
// Testbench top for the Modbus RTU master engine: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module tb_modbus_rtu_master_engine;
  import mbm_pkg::*;

  logic       clk = 0;
  logic       rst = 1;
  logic       start = 0;
  logic       busy;
  cmd_t       cmd = '0;
  logic       strobe;
  res_t       result;
  logic       cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [7:0] cfg_data = 0;
  int         fail_count;
  int         pending_results;
  int         cycle_count = 0;
  bit         allow_gaps = 1;
  // addresses configured in the current phase, used to aim commands at known slaves
  logic [7:0] known_addr[4];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  modbus_rtu_master_engine dut (
    .clk, .rst, .start, .busy, .cmd, .strobe, .result, .cfg_we, .cfg_index, .cfg_data
  );

  mbm_checker chk (
    .clk, .rst, .start, .busy, .cmd, .strobe, .result, .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending_results
  );

  // Timeout: clearing sweep plus the worst case of all items, each with a full
  // idle burst and a longest read-register apply, taken several times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [7:0] d);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // One transfer: optional random idle burst, then hold start until accepted.
  // start stays high on return; the next transfer or settle() takes it over.
  task automatic issue(cmd_t c);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1; cmd <= c;
    do @(posedge clk); while (busy);
  endtask

  // Drain outstanding results; a non-last rx byte has no result, so allow slack.
  task automatic settle();
    start <= 0;
    while (pending_results != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  function automatic cmd_t rand_cmd(mode_t m);
    cmd_t c;
    c.mode = m;
    c.slave_addr = ($urandom_range(0, 7) == 0) ? 8'($urandom) : known_addr[$urandom_range(0, 3)];
    c.item_addr = 16'($urandom);
    c.count_or_value = 16'($urandom);
    c.store_index = 8'($urandom);
    c.rx_byte = 8'($urandom);
    c.rx_last = 0;
    return c;
  endfunction

  // Response frame of a given length; last byte marked.
  task automatic send_reply(int len);
    cmd_t c;
    for (int i = 0; i < len; i++) begin
      c = rand_cmd(MODE_RX);
      c.rx_last = (i == len - 1);
      issue(c);
    end
  endtask

  // Command followed by a reply, mostly of the length the command expects.
  task automatic exchange(mode_t m);
    cmd_t c;
    int   len;
    c = rand_cmd(m);
    // keep read counts small most of the time so replies stay short
    if (m <= MODE_RD_COILS && $urandom_range(0, 9) != 0)
      c.count_or_value = 16'($urandom_range(0, 8));
    issue(c);
    case (m)
      MODE_RD_REGS:  len = 5 + 2 * c.count_or_value;
      MODE_RD_COILS: len = 5 + (c.count_or_value + 7) / 8;
      default:       len = 8;
    endcase
    if (len > 24) len = $urandom_range(5, 24);
    if ($urandom_range(0, 5) == 0) len = $urandom_range(1, 10);
    send_reply(len);
  endtask

  task automatic configure(logic [3:0] mask, logic [7:0] a0, logic [7:0] a1,
                           logic [7:0] a2, logic [7:0] a3);
    known_addr[0] = a0; known_addr[1] = a1; known_addr[2] = a2; known_addr[3] = a3;
    write_cfg(CFG_ADDR0, a0);
    write_cfg(CFG_ADDR1, a1);
    write_cfg(CFG_ADDR2, a2);
    write_cfg(CFG_ADDR3, a3);
    write_cfg(CFG_MASK, {4'h0, mask});
  endtask

  initial begin
    cmd_t c;
    known_addr = '{default: 8'h00};
    repeat (8) @(posedge clk);
    rst <= 0;

    // phase 1: directed, default config (no slave known), then a full set
    c = rand_cmd(MODE_RD_REGS);
    c.slave_addr = 8'h00;
    issue(c);
    c.mode = MODE_NONE;
    issue(c);
    send_reply(3);                                 // no pending command, short
    send_reply(6);                                 // no pending command, stores nothing
    settle();
    configure(4'hF, 8'h00, 8'hFF, 8'h11, 8'h11);   // duplicate addr: lowest slot wins
    c = '0;
    c.mode = MODE_RD_REGS; c.slave_addr = 8'hFF; c.item_addr = 16'hFFFF;
    c.count_or_value = 16'hFFFF; c.store_index = 8'hFF;
    issue(c);
    send_reply(40);                                // count past store end: dropped
    c.mode = MODE_WR_REG; c.slave_addr = 8'h00; c.item_addr = 0; c.count_or_value = 0;
    c.store_index = 0;
    issue(c);
    send_reply(8);
    c.mode = MODE_GET_REG;
    issue(c);
    c.mode = MODE_RD_COILS; c.slave_addr = 8'h11; c.count_or_value = 16'd9; c.store_index = 8'd63;
    issue(c);
    send_reply(7);                                 // coil byte past the end dropped
    c.mode = MODE_GET_COIL; c.store_index = 8'hFF; // query past coil store
    issue(c);
    c.mode = MODE_WR_COIL;
    issue(c);
    send_reply(7);                                 // bad length
    c.mode = MODE_WR_REG;
    issue(c);
    send_reply(260);                               // overlong, bad length
    settle();

    // phase 2: pending slot gets disabled before its reply arrives
    configure(4'h2, 8'h00, 8'h5A, 8'hA5, 8'h01);
    c = rand_cmd(MODE_RD_REGS); c.slave_addr = 8'h5A; c.count_or_value = 2;
    issue(c);
    settle();
    write_cfg(CFG_MASK, 4'h0);
    send_reply(9);
    settle();

    // random phases over several settings
    for (int ph = 0; ph < 4; ph++) begin
      configure(ph == 3 ? 4'hF : 4'($urandom), 8'($urandom), 8'($urandom),
                ph == 0 ? 8'h00 : 8'($urandom), ph == 0 ? 8'hFF : 8'($urandom));
      if (ph == 3) allow_gaps = 0;
      for (int n = 0; n < 8; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: exchange(mode_t'($urandom_range(0, 3)));
          6, 7:             issue(rand_cmd(mode_t'($urandom_range(5, 6))));
          8:                issue(rand_cmd(mode_t'($urandom_range(0, 7))));
          default: begin
            c = rand_cmd(MODE_RX); c.rx_last = 1;
            issue(c);
          end
        endcase
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/mbm_pkg.sv
sv/mbm_ram.sv
sv/mbm_tx.sv
sv/modbus_rtu_master_engine.sv
tb/mbm_checker.sv
tb/tb_modbus_rtu_master_engine.sv
